// ----- rtl/core/bav_pkg.sv -----
`timescale 1ns / 1ps
package bav_pkg;

  typedef logic signed [17:0] ang_t;

  localparam ang_t Q_PI      = 18'sd12868;
  localparam ang_t Q_HALF_PI = 18'sd6434;
  localparam ang_t Q_TWO_PI  = 18'sd25736;

  localparam logic [24:0] ONE24 = 25'd16777216;

  localparam ang_t        KICK_OFFSET      = 18'sd315;
  localparam logic [14:0] NO_TURN_ANGLE    = 15'd410;
  localparam logic [14:0] TURN_FIRST_ANGLE = 15'd2048;
  localparam logic [14:0] QUARTER_PI       = 15'd3217;
  localparam logic [14:0] ALIGN_TOL        = 15'd410;
  localparam logic signed [16:0] SR_LOW    = -17'sd819;
  localparam logic signed [16:0] SR_HIGH   = 17'sd2048;

  // three conditional steps cover every sum of two or three 15-bit angles
  function automatic ang_t wrap_pi(ang_t a);
    ang_t v;
    v = a;
    for (int i = 0; i < 3; i++) begin
      if (v > Q_PI) begin
        v = v - Q_TWO_PI;
      end else if (v < -Q_PI) begin
        v = v + Q_TWO_PI;
      end
    end
    return v;
  endfunction

  // divide by 4096, rounding half away from zero
  function automatic logic signed [27:0] rnd12(logic signed [39:0] v);
    logic [39:0] mag;
    logic [39:0] sh;
    mag = v[39] ? 40'(-v) : 40'(v);
    sh  = (mag + 40'd2048) >> 12;
    return v[39] ? -$signed(sh[27:0]) : $signed(sh[27:0]);
  endfunction

endpackage

// ----- rtl/core/bav_cell.sv -----
`timescale 1ns / 1ps
module bav_cell import bav_pkg::*; #(
  parameter int unsigned DIVISOR = 72
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic        [25:0] x2_i,
  input  logic        [24:0] t_i,
  input  logic signed [13:0] a_i,
  output logic        [25:0] x2_o,
  output logic        [24:0] t_o,
  output logic signed [13:0] a_o
);

  // exact floor division for dividends below 2^26
  localparam logic [30:0] RECIP =
    31'(((64'd1 << 33) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic        [50:0] prod;
  logic        [50:0] prod_rnd;
  logic        [25:0] r_d, r_q;
  logic        [25:0] x2a_q;
  logic signed [13:0] aa_q;
  logic        [56:0] qprod;
  logic        [24:0] t_d, t_q;
  logic        [25:0] x2_q;
  logic signed [13:0] a_q;

  assign prod     = 51'(x2_i) * 51'(t_i);
  assign prod_rnd = prod + 51'd8388608;
  assign r_d      = prod_rnd[49:24];

  assign qprod = 57'(r_q) * 57'(RECIP);
  assign t_d   = ONE24 - {1'b0, qprod[56:33]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q   <= r_d;
      x2a_q <= x2_i;
      aa_q  <= a_i;
      t_q   <= t_d;
      x2_q  <= x2a_q;
      a_q   <= aa_q;
    end
  end

  assign x2_o = x2_q;
  assign t_o  = t_q;
  assign a_o  = a_q;

endmodule

// ----- rtl/core/bav_lane.sv -----
`timescale 1ns / 1ps
module bav_lane import bav_pkg::*; #(
  parameter bit IS_COS = 1'b0
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  ang_t               angle_i,
  output logic signed [13:0] sin_o
);

  localparam int unsigned DIVS [4] = '{72, 42, 20, 6};

  ang_t               w, w2, red;
  logic signed [13:0] a_p_q, a_q_q;
  logic signed [27:0] sq;
  logic        [25:0] x2_q;
  logic        [25:0] x2_c [5];
  logic        [24:0] t_c  [5];
  logic signed [13:0] a_c  [5];
  logic signed [39:0] m_q;
  logic signed [27:0] s1, s2;
  logic signed [13:0] sin_q;

  // reduce to [-pi, pi], shift for cosine, reflect into [-pi/2, pi/2]
  always_comb begin
    w  = wrap_pi(angle_i);
    w2 = IS_COS ? wrap_pi(w + Q_HALF_PI) : w;
    if (w2 > Q_HALF_PI) begin
      red = Q_PI - w2;
    end else if (w2 < -Q_HALF_PI) begin
      red = -Q_PI - w2;
    end else begin
      red = w2;
    end
  end

  assign sq = a_p_q * a_p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_p_q <= red[13:0];
      x2_q  <= sq[25:0];
      a_q_q <= a_p_q;
    end
  end

  assign x2_c[0] = x2_q;
  assign t_c[0]  = ONE24;
  assign a_c[0]  = a_q_q;

  for (genvar g = 0; g < 4; g++) begin : g_cell
    bav_cell #(.DIVISOR(DIVS[g])) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .x2_i  (x2_c[g]),
      .t_i   (t_c[g]),
      .a_i   (a_c[g]),
      .x2_o  (x2_c[g+1]),
      .t_o   (t_c[g+1]),
      .a_o   (a_c[g+1])
    );
  end

  assign s1 = rnd12(m_q);
  assign s2 = rnd12(40'(s1));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q   <= 40'(a_c[4]) * $signed({15'd0, t_c[4]});
      sin_q <= s2[13:0];
    end
  end

  // x2 of the last cell is not needed past the series
  logic unused_x2;
  assign unused_x2 = ^x2_c[4];

  assign sin_o = sin_q;

endmodule

// ----- rtl/core/ball_approach_velocity.sv -----
`timescale 1ns / 1ps
// channel  | valid       | ready       | payload
// input    | in_valid_i  | in_ready_o  | ball_known_i .. robot_heading_i
// result   | out_valid_o | out_ready_i | command_valid_o .. aligned_o
// config   | cfg_valid_i | cfg_ready_o | cfg_index_i, cfg_data_i
//
// one item per cycle while not held; stages to the result: one input stage, the
// 12 stages of the trig lanes (reduction, square, four series cells of two stages,
// product, round), two multiply and sum stages, one output register
// the whole pipeline holds while the output register is full and not taken
// reset clears stage valids and loads the register defaults
module ball_approach_velocity import bav_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               ball_known_i,
  input  logic signed [14:0] kick_direction_i,
  input  logic signed [14:0] ball_field_angle_i,
  input  logic        [14:0] ball_distance_i,
  input  logic signed [14:0] ball_bearing_i,
  input  logic signed [14:0] robot_heading_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               command_valid_o,
  output logic        [14:0] forward_speed_o,
  output logic signed [15:0] lateral_speed_o,
  output logic signed [15:0] turn_rate_o,
  output logic               aligned_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic        [2:0]  cfg_index_i,
  input  logic        [14:0] cfg_data_i
);

  typedef enum logic [2:0] {
    CFG_TARGET_DIST = 3'd0,
    CFG_SIDE_FAR    = 3'd1,
    CFG_SIDE_NEAR   = 3'd2,
    CFG_NEAR_ARC    = 3'd3,
    CFG_TURN_GAIN   = 3'd4,
    CFG_FWD_LIMIT   = 3'd5,
    CFG_LAT_LIMIT   = 3'd6,
    CFG_TURN_LIMIT  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic               known;
    logic               zero_xy;
    logic               aligned;
    logic signed [15:0] vt;
    logic signed [12:0] sr;
    logic        [14:0] st;
  } side_t;

  localparam int unsigned NSTG = 16;
  localparam int unsigned LANE_LAT = 12;

  logic [14:0] target_dist_q, side_far_q, side_near_q, near_arc_q;
  logic [14:0] turn_gain_q, fwd_limit_q, lat_limit_q, turn_limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_dist_q <= 15'd2458;
      side_far_q    <= 15'd1229;
      side_near_q   <= 15'd410;
      near_arc_q    <= 15'd819;
      turn_gain_q   <= 15'd4096;
      fwd_limit_q   <= 15'd2458;
      lat_limit_q   <= 15'd2458;
      turn_limit_q  <= 15'd4096;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TARGET_DIST: target_dist_q <= cfg_data_i;
        CFG_SIDE_FAR:    side_far_q    <= cfg_data_i;
        CFG_SIDE_NEAR:   side_near_q   <= cfg_data_i;
        CFG_NEAR_ARC:    near_arc_q    <= cfg_data_i;
        CFG_TURN_GAIN:   turn_gain_q   <= cfg_data_i;
        CFG_FWD_LIMIT:   fwd_limit_q   <= cfg_data_i;
        CFG_LAT_LIMIT:   lat_limit_q   <= cfg_data_i;
        CFG_TURN_LIMIT:  turn_limit_q  <= cfg_data_i;
        default:         target_dist_q <= target_dist_q;
      endcase
    end
  end

  // pipeline control
  logic            en;
  logic [NSTG-1:0] vld_q;

  assign en         = ~vld_q[NSTG-1] | out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  // first stage: angle error, speeds, turn rate, flags
  ang_t               kick_x, field_x, head_x, dsum, d, tr, tt;
  logic        [13:0] ad;
  logic        [14:0] ab;
  logic signed [15:0] bear_x;
  logic        [28:0] arc;
  logic signed [16:0] diff;
  logic signed [12:0] sr;
  logic        [14:0] st;
  logic signed [30:0] gprod;
  logic signed [27:0] vt_r, vt_z, vt_lim, vt_c;
  side_t              side_d;

  always_comb begin
    kick_x  = 18'(kick_direction_i);
    field_x = 18'(ball_field_angle_i);
    head_x  = 18'(robot_heading_i);
    bear_x  = 16'(ball_bearing_i);
    dsum    = kick_x - field_x + KICK_OFFSET;
    d       = wrap_pi(dsum);
    ad      = d[17] ? 14'(-d) : 14'(d);
    ab      = bear_x[15] ? 15'(-bear_x) : 15'(bear_x);
    arc     = 29'(ad) * 29'(ball_distance_i);
    st      = (arc < {2'b00, near_arc_q, 12'd0}) ? side_near_q : side_far_q;
    diff    = $signed({2'b00, ball_distance_i}) - $signed({2'b00, target_dist_q});
    if (diff < SR_LOW) begin
      sr = SR_LOW[12:0];
    end else if (diff > SR_HIGH) begin
      sr = SR_HIGH[12:0];
    end else begin
      sr = diff[12:0];
    end
    tr = field_x - head_x;
    tt = (d > 18'sd0) ? tr - Q_HALF_PI : tr + Q_HALF_PI;

    gprod  = $signed({1'b0, turn_gain_q}) * ball_bearing_i;
    vt_r   = rnd12(40'(gprod));
    vt_z   = (ab < NO_TURN_ANGLE) ? 28'sd0 : vt_r;
    vt_lim = $signed({13'd0, turn_limit_q});
    if (vt_z > vt_lim) begin
      vt_c = vt_lim;
    end else if (vt_z < -vt_lim) begin
      vt_c = -vt_lim;
    end else begin
      vt_c = vt_z;
    end

    side_d.known   = ball_known_i;
    side_d.zero_xy = (ab > TURN_FIRST_ANGLE) && ({1'b0, ad} < QUARTER_PI);
    side_d.aligned = ({1'b0, ad} <= ALIGN_TOL) && (ab <= ALIGN_TOL) &&
                     ({1'b0, ball_distance_i} <
                      ({1'b0, target_dist_q} + {1'b0, ALIGN_TOL}));
    side_d.vt      = vt_c[15:0];
    side_d.sr      = sr;
    side_d.st      = st;
  end

  side_t side_q [LANE_LAT+1];
  ang_t  tt_q, tr_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      tt_q      <= tt;
      tr_q      <= tr;
      for (int i = 1; i <= LANE_LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  logic signed [13:0] sin_tt, cos_tt, sin_tr, cos_tr;

  bav_lane #(.IS_COS(1'b0)) u_sin_tt (
    .clk_i(clk_i), .en_i(en), .angle_i(tt_q), .sin_o(sin_tt));
  bav_lane #(.IS_COS(1'b1)) u_cos_tt (
    .clk_i(clk_i), .en_i(en), .angle_i(tt_q), .sin_o(cos_tt));
  bav_lane #(.IS_COS(1'b0)) u_sin_tr (
    .clk_i(clk_i), .en_i(en), .angle_i(tr_q), .sin_o(sin_tr));
  bav_lane #(.IS_COS(1'b1)) u_cos_tr (
    .clk_i(clk_i), .en_i(en), .angle_i(tr_q), .sin_o(cos_tr));

  // speed times trig, then sum and round
  side_t              side_c1_q, side_c2_q;
  logic signed [29:0] px_st_q, px_sr_q, py_st_q, py_sr_q;
  logic signed [30:0] sum_x, sum_y;
  logic signed [27:0] vx_r, vy_r;
  logic signed [19:0] vx_q, vy_q;

  assign sum_x = 31'(px_st_q) + 31'(px_sr_q);
  assign sum_y = 31'(py_st_q) + 31'(py_sr_q);
  assign vx_r  = rnd12(40'(sum_x));
  assign vy_r  = rnd12(40'(sum_y));

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_c1_q <= side_q[LANE_LAT];
      px_st_q   <= $signed({1'b0, side_q[LANE_LAT].st}) * cos_tt;
      py_st_q   <= $signed({1'b0, side_q[LANE_LAT].st}) * sin_tt;
      px_sr_q   <= 30'(side_q[LANE_LAT].sr) * 30'(cos_tr);
      py_sr_q   <= 30'(side_q[LANE_LAT].sr) * 30'(sin_tr);
      side_c2_q <= side_c1_q;
      vx_q      <= vx_r[19:0];
      vy_q      <= vy_r[19:0];
    end
  end

  // turn-first zeroing and limits into the output register
  logic signed [19:0] vx_z, vy_z, fwd_lim, lat_lim;
  logic        [14:0] fwd_d;
  logic signed [15:0] lat_d;

  always_comb begin
    vx_z    = side_c2_q.zero_xy ? 20'sd0 : vx_q;
    vy_z    = side_c2_q.zero_xy ? 20'sd0 : vy_q;
    fwd_lim = $signed({5'd0, fwd_limit_q});
    lat_lim = $signed({5'd0, lat_limit_q});
    if (vx_z < 20'sd0) begin
      fwd_d = 15'd0;
    end else if (vx_z > fwd_lim) begin
      fwd_d = fwd_limit_q;
    end else begin
      fwd_d = vx_z[14:0];
    end
    if (vy_z > lat_lim) begin
      lat_d = lat_lim[15:0];
    end else if (vy_z < -lat_lim) begin
      lat_d = 16'(-lat_lim);
    end else begin
      lat_d = vy_z[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      command_valid_o <= side_c2_q.known;
      forward_speed_o <= side_c2_q.known ? fwd_d : 15'd0;
      lateral_speed_o <= side_c2_q.known ? lat_d : 16'sd0;
      turn_rate_o     <= side_c2_q.known ? side_c2_q.vt : 16'sd0;
      aligned_o       <= side_c2_q.known & side_c2_q.aligned;
    end
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import bav_pkg::*;

  typedef enum logic [2:0] {
    REG_TARGET_DIST, REG_SIDE_FAR, REG_SIDE_NEAR, REG_NEAR_ARC,
    REG_TURN_GAIN, REG_FWD_LIMIT, REG_LAT_LIMIT, REG_TURN_LIMIT
  } cfg_reg_e;

  typedef struct packed {
    logic               known;
    logic signed [14:0] kick;
    logic signed [14:0] field;
    logic        [14:0] distance;
    logic signed [14:0] bearing;
    logic signed [14:0] heading;
  } sample_t;

  typedef struct packed {
    logic               cmd_valid;
    logic        [14:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vt;
    logic               aligned;
  } command_t;

  localparam longint ANG_PI   = 12868;
  localparam longint ANG_HALF = 6434;
  localparam longint ANG_QUAR = 3217;
  localparam longint ANG_2PI  = 25736;
  localparam longint UNIT24   = 64'd16777216;
  localparam int     SETTLE   = 24;
  localparam int     WDOG_MAX = 4000;

  class velocity_scoreboard;
    logic [14:0] regs[8];
    command_t    pending_commands[$];
    int          mismatches;
    int          commands_seen;

    function new();
      regs[REG_TARGET_DIST] = 15'd2458;
      regs[REG_SIDE_FAR]    = 15'd1229;
      regs[REG_SIDE_NEAR]   = 15'd410;
      regs[REG_NEAR_ARC]    = 15'd819;
      regs[REG_TURN_GAIN]   = 15'd4096;
      regs[REG_FWD_LIMIT]   = 15'd2458;
      regs[REG_LAT_LIMIT]   = 15'd2458;
      regs[REG_TURN_LIMIT]  = 15'd4096;
      mismatches = 0;
      commands_seen = 0;
    endfunction

    function longint rnd12(longint p);
      return (p >= 0) ? (p + 2048) >>> 12 : -((-p + 2048) >>> 12);
    endfunction

    function longint rnd24(longint p);
      return (p >= 0) ? (p + 64'd8388608) >>> 24 : -((-p + 64'd8388608) >>> 24);
    endfunction

    function longint wrap_angle(longint a);
      longint v;
      v = a;
      while (v > ANG_PI) v = v - ANG_2PI;
      while (v < -ANG_PI) v = v + ANG_2PI;
      return v;
    endfunction

    function longint clampl(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // taylor series to x^9 in Q8.24 on the angle folded into +-pi/2
    function longint sine_q12(longint a);
      longint r, x, x2, t;
      r = wrap_angle(a);
      if (r > ANG_HALF) r = ANG_PI - r;
      else if (r < -ANG_HALF) r = -ANG_PI - r;
      x  = r * 4096;
      x2 = rnd24(x * x);
      t  = UNIT24;
      t  = UNIT24 - rnd24(x2 * t) / 72;
      t  = UNIT24 - rnd24(x2 * t) / 42;
      t  = UNIT24 - rnd24(x2 * t) / 20;
      t  = UNIT24 - rnd24(x2 * t) / 6;
      return rnd12(rnd24(x * t));
    endfunction

    function longint cosine_q12(longint a);
      return sine_q12(wrap_angle(a) + ANG_HALF);
    endfunction

    function command_t approach_command(sample_t s);
      command_t c;
      longint kick, field, bearing, heading, ball_dist, d, ad, ab;
      longint tgt, sr, st, tr, tt, vx, vy, vt;
      c = '0;
      if (!s.known) return c;
      kick = s.kick; field = s.field; bearing = s.bearing; heading = s.heading;
      ball_dist = longint'(s.distance);
      tgt  = longint'(regs[REG_TARGET_DIST]);
      d  = wrap_angle(kick - field + 315);
      ad = (d < 0) ? -d : d;
      ab = (bearing < 0) ? -bearing : bearing;
      sr = clampl(ball_dist - tgt, -819, 2048);
      st = longint'(regs[REG_SIDE_FAR]);
      if (ad * ball_dist < (longint'(regs[REG_NEAR_ARC]) <<< 12))
        st = longint'(regs[REG_SIDE_NEAR]);
      tr = field - heading;
      tt = tr + ((d > 0) ? -ANG_HALF : ANG_HALF);
      vx = rnd12(st * cosine_q12(tt) + sr * cosine_q12(tr));
      vy = rnd12(st * sine_q12(tt) + sr * sine_q12(tr));
      vt = rnd12(longint'(regs[REG_TURN_GAIN]) * bearing);
      if (ab < 410) vt = 0;
      // turn first: big bearing with the kick line roughly lined up
      if (ab > 2048 && ad < ANG_QUAR) begin
        vx = 0;
        vy = 0;
      end
      vx = clampl(vx, 0, longint'(regs[REG_FWD_LIMIT]));
      vy = clampl(vy, -longint'(regs[REG_LAT_LIMIT]), longint'(regs[REG_LAT_LIMIT]));
      vt = clampl(vt, -longint'(regs[REG_TURN_LIMIT]), longint'(regs[REG_TURN_LIMIT]));
      c.cmd_valid = 1'b1;
      c.vx = vx[14:0];
      c.vy = vy[15:0];
      c.vt = vt[15:0];
      c.aligned = (ad <= 410) && (ab <= 410) && (ball_dist < tgt + 410);
      return c;
    endfunction

    function void note_sample(sample_t s);
      pending_commands.push_back(approach_command(s));
    endfunction

    task report_mismatch(string what);
      $display("mismatch: %s", what);
      mismatches++;
    endtask

    task check_command(command_t got);
      command_t exp;
      commands_seen++;
      if (pending_commands.size() == 0) begin
        report_mismatch("result with nothing outstanding");
        return;
      end
      exp = pending_commands.pop_front();
      if (got.cmd_valid !== exp.cmd_valid)
        report_mismatch($sformatf("command_valid %0b exp %0b", got.cmd_valid, exp.cmd_valid));
      if (got.vx !== exp.vx)
        report_mismatch($sformatf("forward_speed %0d exp %0d", got.vx, exp.vx));
      if (got.vy !== exp.vy)
        report_mismatch($sformatf("lateral_speed %0d exp %0d", got.vy, exp.vy));
      if (got.vt !== exp.vt)
        report_mismatch($sformatf("turn_rate %0d exp %0d", got.vt, exp.vt));
      if (got.aligned !== exp.aligned)
        report_mismatch($sformatf("aligned %0b exp %0b", got.aligned, exp.aligned));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               ball_known_i = 1'b0;
  logic signed [14:0] kick_direction_i = '0;
  logic signed [14:0] ball_field_angle_i = '0;
  logic        [14:0] ball_distance_i = '0;
  logic signed [14:0] ball_bearing_i = '0;
  logic signed [14:0] robot_heading_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               command_valid_o;
  logic        [14:0] forward_speed_o;
  logic signed [15:0] lateral_speed_o;
  logic signed [15:0] turn_rate_o;
  logic               aligned_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic        [2:0]  cfg_index_i = '0;
  logic        [14:0] cfg_data_i = '0;

  velocity_scoreboard sb = new();
  logic no_idle = 1'b0;
  logic rx_hold = 1'b0;
  int   samples_sent = 0;
  int   quiet_cycles = 0;

  ball_approach_velocity i_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rx_hold) out_ready_i <= 1'b0;
    else if (no_idle) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(99) >= 28);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      sb.note_sample({ball_known_i, kick_direction_i, ball_field_angle_i, ball_distance_i,
                      ball_bearing_i, robot_heading_i});
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_command({command_valid_o, forward_speed_o, lateral_speed_o, turn_rate_o,
                        aligned_o});
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_MAX) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(sample_t s);
    if (!no_idle && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    ball_known_i       <= s.known;
    kick_direction_i   <= s.kick;
    ball_field_angle_i <= s.field;
    ball_distance_i    <= s.distance;
    ball_bearing_i     <= s.bearing;
    robot_heading_i    <= s.heading;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    samples_sent++;
  endtask

  // valid stays high across back to back writes; the caller drops it
  task automatic write_reg(cfg_reg_e idx, logic [14:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    sb.regs[idx] = value;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_commands.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic sample_t make_sample(logic known, int kick, int field, int distance,
                                          int bearing, int heading);
    sample_t s;
    s.known = known; s.kick = kick[14:0]; s.field = field[14:0];
    s.distance = distance[14:0]; s.bearing = bearing[14:0]; s.heading = heading[14:0];
    return s;
  endfunction

  function automatic int rand_angle();
    return $urandom_range(25736) - 12868;
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    int pick;
    pick = $urandom_range(99);
    s = make_sample(1'b1, rand_angle(), rand_angle(), $urandom_range(8192), rand_angle(),
                    rand_angle());
    if (pick < 8) begin
      s.known = 1'b0;
    end else if (pick < 18) begin
      s.known    = 1'b1;
      s.kick     = 15'($urandom());
      s.field    = 15'($urandom());
      s.distance = 15'($urandom());
      s.bearing  = 15'($urandom());
      s.heading  = 15'($urandom());
    end else if (pick < 40) begin
      // near the kick line, close in and facing the ball
      s.field    = 15'(s.kick + 315 + $urandom_range(800) - 400);
      s.distance = 15'(sb.regs[REG_TARGET_DIST] + $urandom_range(1200) - 600);
      s.bearing  = 15'($urandom_range(1000) - 500);
    end else if (pick < 50) begin
      s.bearing = $urandom_range(1) ? 15'(2049 + $urandom_range(8000))
                                    : -15'(2049 + $urandom_range(8000));
    end else if (pick < 60) begin
      s.distance = 15'($urandom());
    end
    return s;
  endfunction

  task automatic run_random(int count);
    repeat (count) send_sample(random_sample());
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: unknown ball, angle and distance extremes, turn first, aligned
    send_sample(make_sample(1'b0, 12868, -12868, 32767, 12868, -12868));
    send_sample(make_sample(1'b1, -315, 0, 2458, 0, 0));
    send_sample(make_sample(1'b1, -315, 0, 2458, 410, 100));
    send_sample(make_sample(1'b1, -315, 0, 2868, -410, 100));
    send_sample(make_sample(1'b1, -315, 0, 2000, 409, 0));
    send_sample(make_sample(1'b1, 12868, -12868, 0, 12868, 12868));
    send_sample(make_sample(1'b1, -12868, 12868, 32767, -12868, -12868));
    send_sample(make_sample(1'b1, 16383, -16384, 32767, 16383, -16384));
    send_sample(make_sample(1'b1, -16384, 16383, 0, -16384, 16383));
    send_sample(make_sample(1'b1, 0, 0, 3000, 2049, 0));
    send_sample(make_sample(1'b1, 0, 0, 3000, -2049, 500));
    send_sample(make_sample(1'b1, 0, 0, 3000, 2048, 500));
    send_sample(make_sample(1'b1, 6434, 0, 5000, 3000, 0));
    send_sample(make_sample(1'b1, -300, 0, 100, 0, 1000));
    send_sample(make_sample(1'b1, -330, 0, 100, 0, -1000));
    send_sample(make_sample(1'b1, 3000, 0, 20000, 0, -6434));
    send_sample(make_sample(1'b1, -3000, 0, 1000, 0, 6434));
    send_sample(make_sample(1'b1, 0, -12868, 2458, 12000, 0));
    send_sample(make_sample(1'b1, 0, 0, 2458, -12000, 0));
    send_sample(make_sample(1'b1, 12553, 0, 800, 200, 3000));
    drain();

    // stall the receiver with the sender running flat out
    no_idle = 1'b1;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (300) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
    join_none
    run_random(300);
    drain();
    no_idle = 1'b0;
    run_random(200);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      for (int r = 0; r < 8; r++) begin
        case (ph)
          0: write_reg(cfg_reg_e'(r), 15'h7fff);
          1: write_reg(cfg_reg_e'(r), 15'h0000);
          2: write_reg(cfg_reg_e'(r), 15'($urandom_range(6000)));
          3: write_reg(cfg_reg_e'(r), 15'($urandom()));
          default: write_reg(cfg_reg_e'(r), 15'($urandom_range(1000, 5000)));
        endcase
      end
      cfg_valid_i <= 1'b0;
      run_random(260);
      drain();
    end

    $display("covered %0d samples and %0d commands over 6 register settings",
             samples_sent, sb.commands_seen);
    $display("register extremes, receiver hold-off and input stall exercised");
    if (sb.mismatches == 0 && sb.pending_commands.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- ball_approach_velocity.f -----
rtl/core/bav_pkg.sv
rtl/core/bav_cell.sv
rtl/core/bav_lane.sv
rtl/core/ball_approach_velocity.sv
verif/testbench.sv
